>>> rtl/position_to_analog_level_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for position_to_analog_level
// Shared concurrent-assertion shorthands, clocked on clk_i, muted in reset.
// ----------------------------------------------------------------------------
`ifndef POSITION_TO_ANALOG_LEVEL_ASSERT_SVH
`define POSITION_TO_ANALOG_LEVEL_ASSERT_SVH

// Same-cycle implication.
`define PAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Types and constants shared by the position-to-analog-level datapath.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int unsigned IN_W    = 64;
  localparam int unsigned DIV_W   = 41;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned PROD_W  = DIV_W + LEVEL_W;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'hFFFF;
  localparam logic [LEVEL_W-1:0] MID_SCALE  = 16'h8000;
  localparam logic [IN_W-1:0]    MAX_SPAN   = 64'h0000_0100_0000_0000;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_WRAP  = 2'd1,
    MODE_DISP  = 2'd2,
    MODE_SPEED = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 8'd0,
    REG_WRAP_RANGE = 8'd1,
    REG_SPAN_LOW   = 8'd2,
    REG_SPAN_HIGH  = 8'd3
  } reg_idx_e;

  // Sideband through the modulo chain
  typedef struct packed {
    logic             neg;
    logic             sat_lo;
    logic             sat_hi;
    logic [DIV_W-1:0] offs;
  } mod_side_t;

  // Sideband through the scaling chain
  typedef struct packed {
    logic sat_lo;
    logic sat_hi;
  } scl_side_t;

endpackage

>>> rtl/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell
// One restoring-division step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
module pal_cell
  import pal_pkg::*;
#(
  parameter int unsigned NUM_W  = 16,
  parameter int unsigned SIDE_W = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [DIV_W-1:0]  div_i,
  input  logic              valid_i,
  input  logic [DIV_W-1:0]  rem_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [DIV_W-1:0]  rem_o,
  output logic [NUM_W-1:0]  num_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              valid_q;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [SIDE_W-1:0] side_q;
  logic [DIV_W:0]    shifted, diff;
  logic              ge;

  always_comb begin
    shifted = {rem_i, num_i[NUM_W-1]};
    diff    = shifted - {1'b0, div_i};
    ge      = (shifted >= {1'b0, div_i});
    rem_d   = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    // quotient bit enters at the bottom as the dividend leaves the top
    num_d   = {num_i[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      num_q  <= num_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign side_o  = side_q;

endmodule

>>> rtl/pal_chain.sv
// ----------------------------------------------------------------------------
// pal_chain
// Row of division cells, one dividend bit per cell.
// ----------------------------------------------------------------------------
module pal_chain
  import pal_pkg::*;
#(
  parameter int unsigned NUM_W  = 16,
  parameter int unsigned SIDE_W = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [DIV_W-1:0]  div_i,
  input  logic              valid_i,
  input  logic [DIV_W-1:0]  rem_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [DIV_W-1:0]  rem_o,
  output logic [NUM_W-1:0]  quot_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              valid_w [NUM_W+1];
  logic [DIV_W-1:0]  rem_w   [NUM_W+1];
  logic [NUM_W-1:0]  num_w   [NUM_W+1];
  logic [SIDE_W-1:0] side_w  [NUM_W+1];

  assign valid_w[0] = valid_i;
  assign rem_w[0]   = rem_i;
  assign num_w[0]   = num_i;
  assign side_w[0]  = side_i;

  for (genvar g = 0; g < NUM_W; g++) begin : g_cell
    pal_cell #(
      .NUM_W  (NUM_W),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .div_i   (div_i),
      .valid_i (valid_w[g]),
      .rem_i   (rem_w[g]),
      .num_i   (num_w[g]),
      .side_i  (side_w[g]),
      .valid_o (valid_w[g+1]),
      .rem_o   (rem_w[g+1]),
      .num_o   (num_w[g+1]),
      .side_o  (side_w[g+1])
    );
  end

  assign valid_o = valid_w[NUM_W];
  assign rem_o   = rem_w[NUM_W];
  assign quot_o  = num_w[NUM_W];
  assign side_o  = side_w[NUM_W];

endmodule

>>> rtl/position_to_analog_level.sv
// ----------------------------------------------------------------------------
// position_to_analog_level
// Maps a displacement or speed sample to a 16-bit analog level by mode.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while the output is not stalled and returns one
// result per sample, in order, through one input stage, 64 cells that take the
// displacement magnitude modulo wrap_range one bit per cell, one stage that
// fixes the sign and multiplies by 65535, 16 cells that divide by the wrap
// range or span width one quotient bit per cell, and the output register.
// The whole row advances together; a stalled output holds every stage.
// Write configuration only while no sample is in flight. Off mode gives
// midscale; an invalid range or span raises config_bad and gives midscale.
// ----------------------------------------------------------------------------
module position_to_analog_level
  import pal_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [IN_W-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [IN_W-1:0] displacement_i,
  input  logic signed [IN_W-1:0] speed_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LEVEL_W-1:0]   level_o,
  output logic                 config_bad_o
);

  localparam int unsigned MOD_SIDE_W = $bits(mod_side_t);
  localparam int unsigned SCL_SIDE_W = $bits(scl_side_t);

  // configuration registers
  mode_e                   mode_q;
  logic [DIV_W-1:0]        wrap_range_q;
  logic signed [IN_W-1:0]  span_low_q, span_high_q;

  logic advance;
  logic [IN_W-1:0] span_diff;
  logic            bad;

  // input stage
  logic              pre_valid_q;
  logic [IN_W-1:0]   pre_mag_q;
  mod_side_t         pre_side_q, pre_side_d;
  logic signed [IN_W-1:0] sel;
  logic [IN_W-1:0]   sel_offs;

  // modulo chain
  logic              mod_valid;
  logic [DIV_W-1:0]  mod_rem;
  logic [IN_W-1:0]   mod_quot;
  logic [MOD_SIDE_W-1:0] mod_side_raw;
  mod_side_t         mod_side;

  // scale stage
  logic              mid_valid_q;
  logic [PROD_W-1:0] mid_prod_q;
  scl_side_t         mid_side_q;
  logic [DIV_W-1:0]  wrapped, src;
  logic [DIV_W-1:0]  scl_div;

  // scaling chain
  logic               scl_valid;
  logic [DIV_W-1:0]   scl_rem;
  logic [LEVEL_W-1:0] scl_quot;
  logic [SCL_SIDE_W-1:0] scl_side_raw;
  scl_side_t          scl_side;

  // output register
  logic               out_valid_q;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic               bad_q;

  // Take writes at any time; the register index picks the target.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_OFF;
      wrap_range_q <= DIV_W'(1);
      span_low_q   <= '0;
      span_high_q  <= IN_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MODE:       mode_q       <= mode_e'(cfg_data_i[1:0]);
        REG_WRAP_RANGE: wrap_range_q <= cfg_data_i[DIV_W-1:0];
        REG_SPAN_LOW:   span_low_q   <= cfg_data_i;
        REG_SPAN_HIGH:  span_high_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The user must hold configuration steady while samples are in flight; the
  // block does not enforce it, and every stage reads it directly.
  always_comb begin
    span_diff = span_high_q - span_low_q;
    bad = 1'b0;
    unique case (mode_q)
      MODE_WRAP: bad = (wrap_range_q == '0) || ({23'd0, wrap_range_q} > MAX_SPAN);
      MODE_DISP, MODE_SPEED: bad = !(span_low_q < span_high_q) || (span_diff > MAX_SPAN);
      default:   bad = 1'b0;
    endcase
  end

  // Advance the whole row unless a finished result waits on the output.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  // Input stage: magnitude for the modulo, saturation and offset for clamp.
  always_comb begin
    sel      = (mode_q == MODE_SPEED) ? speed_i : displacement_i;
    sel_offs = sel - span_low_q;
    pre_side_d.neg    = displacement_i[IN_W-1];
    pre_side_d.sat_lo = !(span_low_q < sel);
    pre_side_d.sat_hi = !(sel < span_high_q);
    pre_side_d.offs   = sel_offs[DIV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= 1'b0;
    end else if (advance) begin
      pre_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pre_mag_q  <= displacement_i[IN_W-1] ? (IN_W'(0) - displacement_i) : displacement_i;
      pre_side_q <= pre_side_d;
    end
  end

  pal_chain #(
    .NUM_W  (IN_W),
    .SIDE_W (MOD_SIDE_W)
  ) u_mod_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .div_i   (wrap_range_q),
    .valid_i (pre_valid_q),
    .rem_i   ('0),
    .num_i   (pre_mag_q),
    .side_i  (pre_side_q),
    .valid_o (mod_valid),
    .rem_o   (mod_rem),
    .quot_o  (mod_quot),
    .side_o  (mod_side_raw)
  );

  assign mod_side = mod_side_t'(mod_side_raw);

  // Floor the remainder for negative displacement, then times 65535.
  always_comb begin
    wrapped = (mod_side.neg && (mod_rem != '0)) ? (wrap_range_q - mod_rem) : mod_rem;
    src     = (mode_q == MODE_WRAP) ? wrapped : mod_side.offs;
    scl_div = (mode_q == MODE_WRAP) ? wrap_range_q : span_diff[DIV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (advance) begin
      mid_valid_q <= mod_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mid_prod_q        <= {src, LEVEL_W'(0)} - PROD_W'(src);
      mid_side_q.sat_lo <= mod_side.sat_lo;
      mid_side_q.sat_hi <= mod_side.sat_hi;
    end
  end

  // Product over divisor stays below 2^16, so the top bits start as remainder.
  pal_chain #(
    .NUM_W  (LEVEL_W),
    .SIDE_W (SCL_SIDE_W)
  ) u_scl_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .div_i   (scl_div),
    .valid_i (mid_valid_q),
    .rem_i   (mid_prod_q[PROD_W-1:LEVEL_W]),
    .num_i   (mid_prod_q[LEVEL_W-1:0]),
    .side_i  (mid_side_q),
    .valid_o (scl_valid),
    .rem_o   (scl_rem),
    .quot_o  (scl_quot),
    .side_o  (scl_side_raw)
  );

  assign scl_side = scl_side_t'(scl_side_raw);

  always_comb begin
    level_d = MID_SCALE;
    if (!bad) begin
      unique case (mode_q)
        MODE_WRAP: level_d = scl_quot;
        MODE_DISP, MODE_SPEED: begin
          if (scl_side.sat_lo) begin
            level_d = '0;
          end else if (scl_side.sat_hi) begin
            level_d = FULL_SCALE;
          end else begin
            level_d = scl_quot;
          end
        end
        default: level_d = MID_SCALE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= scl_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      level_q <= level_d;
      bad_q   <= bad;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign level_o      = level_q;
  assign config_bad_o = bad_q;

  `include "position_to_analog_level_assert.svh"

  `PAL_ASSERT_NOW(a_bad_mid, out_valid_o && config_bad_o, level_o == MID_SCALE, "bad config without midscale")
  `PAL_ASSERT_NOW(a_off_mid, out_valid_o && (mode_q == MODE_OFF), !config_bad_o && (level_o == MID_SCALE), "off mode result not midscale")
  `PAL_ASSERT_NOW(a_stall_blocks, out_valid_o && !out_ready_i, !in_ready_o, "input taken during output stall")
  `PAL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(level_o) && $stable(config_bad_o), "waiting result changed")

endmodule
